@@ hdl/hsled_pkg.sv @@
package hsled_pkg;

    localparam int CNT_W = 12;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] HOLD_RESET = 12'd300;
    localparam int NUM_STEPS = 4;

    // Lamp bit positions in the status and pin words.
    localparam int B_TEMP_INV = 0;
    localparam int B_TEMP_ACCU = 1;
    localparam int B_READY = 2;
    localparam int B_SHUTDOWN = 3;
    localparam int B_FAULT = 4;
    localparam int B_BRAKE = 5;
    localparam int B_INSUL = 6;
    localparam int B_ACCU_MON = 7;

    localparam logic [7:0] SEQ_MASK = 8'h0F;

    typedef struct packed {
        logic frame_valid;
        logic ams_ok;
        logic bspd_ok;
        logic imd_ok;
        logic shutdown_closed;
        logic ready_to_drive;
        logic inverter_temp_warn;
        logic accu_temp_warn;
        logic inverter_fault;
        logic button_pressed;
    } t_tick;

    // Status of the hold counter for the tick being processed.
    typedef struct packed {
        logic [NUM_STEPS-1:0] at_step;
        logic                 expire;
    } t_hold_info;

    typedef struct packed {
        logic       req_off;
        logic       req_start;
        logic [7:0] pins;
    } t_result;

endpackage

@@ hdl/hsled_hold_cnt.sv @@
module hsled_hold_cnt
    import hsled_pkg::*;
#(
    parameter int STEP_TICKS = 60
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_button,
    input  logic [CNT_W-1:0] i_hold_ticks,
    output t_hold_info       o_info
);

    localparam int PH_W = $clog2(NUM_STEPS * STEP_TICKS);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [PH_W-1:0]  r_phase [NUM_STEPS];
    logic [PH_W-1:0]  n_phase [NUM_STEPS];
    logic [PH_W-1:0]  inc_phase [NUM_STEPS];
    logic [CNT_W-1:0] inc_count;
    logic             can_inc;

    // Each phase counter runs modulo (k+1)*STEP_TICKS in step with the hold count,
    // so a phase of zero marks a multiple without any divider.
    always_comb begin
        can_inc   = (r_count != CNT_MAX);
        inc_count = can_inc ? r_count + 1'b1 : r_count;
        for (int k = 0; k < NUM_STEPS; k++) begin
            if (!can_inc) begin
                inc_phase[k] = r_phase[k];
            end else if (r_phase[k] == PH_W'((k + 1) * STEP_TICKS - 1)) begin
                inc_phase[k] = '0;
            end else begin
                inc_phase[k] = r_phase[k] + 1'b1;
            end
            o_info.at_step[k] = i_button && (inc_phase[k] == '0);
        end
        o_info.expire = i_button && (inc_count > i_hold_ticks);

        if (i_button && !o_info.expire) begin
            n_count = inc_count;
            for (int k = 0; k < NUM_STEPS; k++) begin
                n_phase[k] = inc_phase[k];
            end
        end else begin
            n_count = '0;
            for (int k = 0; k < NUM_STEPS; k++) begin
                n_phase[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < NUM_STEPS; k++) begin
                r_phase[k] <= '0;
            end
        end else if (i_adv) begin
            r_count <= n_count;
            for (int k = 0; k < NUM_STEPS; k++) begin
                r_phase[k] <= n_phase[k];
            end
        end
    end

endmodule

@@ hdl/hsled_lamp_ctl.sv @@
module hsled_lamp_ctl
    import hsled_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  t_tick      i_tick,
    input  t_hold_info i_info,
    output t_result    o_result
);

    logic       r_mode;
    logic       n_mode;
    logic [7:0] r_status;
    logic [7:0] n_status;
    logic [7:0] r_pins;
    logic [7:0] frame_status;
    logic [7:0] seq_bits;

    always_comb begin
        frame_status               = '0;
        frame_status[B_TEMP_INV]   = i_tick.inverter_temp_warn;
        frame_status[B_TEMP_ACCU]  = i_tick.accu_temp_warn;
        frame_status[B_READY]      = i_tick.ready_to_drive;
        frame_status[B_SHUTDOWN]   = i_tick.shutdown_closed;
        frame_status[B_FAULT]      = i_tick.inverter_fault;
        frame_status[B_BRAKE]      = ~i_tick.bspd_ok;
        frame_status[B_INSUL]      = ~i_tick.imd_ok;
        frame_status[B_ACCU_MON]   = ~i_tick.ams_ok;

        // A frame in the same tick takes effect before the button logic.
        n_status = i_tick.frame_valid ? frame_status : r_status;
        n_mode   = i_tick.frame_valid ? i_tick.ready_to_drive : r_mode;

        // Mode 1 lights the four sequence lamps in reverse order.
        seq_bits = '0;
        for (int k = 0; k < NUM_STEPS; k++) begin
            if (n_mode) begin
                seq_bits[NUM_STEPS-1-k] = i_info.at_step[k];
            end else begin
                seq_bits[k] = i_info.at_step[k];
            end
        end

        o_result.req_start = 1'b0;
        o_result.req_off   = 1'b0;
        if (i_tick.button_pressed) begin
            o_result.pins = r_pins | seq_bits;
            if (i_info.expire) begin
                o_result.pins      = o_result.pins & ~SEQ_MASK;
                o_result.req_start = ~n_mode;
                o_result.req_off   = n_mode;
            end
        end else begin
            o_result.pins = n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_status <= '0;
            r_pins   <= '0;
        end else if (i_adv) begin
            r_mode   <= n_mode;
            r_status <= n_status;
            r_pins   <= o_result.pins;
        end
    end

endmodule

@@ hdl/hold_to_start_button_led_sequencer_unit.sv @@
// Channel  | Direction | Signals                       | Content
// ---------+-----------+-------------------------------+---------------------------------
// s_axis   | in        | tvalid tready tdata[15:0] tuser | one 10 ms tick with button level
// m_axis   | out       | tvalid tready tdata[15:0]     | lamp levels and request pulses
// cfg      | in        | i_cfg_we i_cfg_wdata[11:0]    | hold limit, reset value 300
//
// One tick per clock cycle while m_axis takes results; a tick's result enters the output
// register in the cycle after its transaction. The throughput is set by the single output
// register, which is loaded in the same cycle that it is emptied.
// Reset is synchronous and active low; it clears the counters, status, mode and lamps.
// A stall on m_axis holds the result and deasserts s_axis_tready until it is taken.
module hold_to_start_button_led_sequencer_unit
    import hsled_pkg::*;
#(
    parameter int STEP_TICKS = 60
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] ams_ok, [1] bspd_ok, [2] imd_ok, [3] shutdown_closed, [4] ready_to_drive,
    // [5] inverter_temp_warn, [6] accu_temp_warn, [7] inverter_fault,
    // [8] button_pressed, [15:9] zero
    input  logic [15:0] s_axis_tdata,
    // [0] frame_valid
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] lamp_temp_inv, [1] lamp_temp_accu, [2] lamp_ready, [3] lamp_shutdown,
    // [4] lamp_fault, [5] lamp_brake, [6] lamp_insulation, [7] lamp_accu_monitor,
    // [8] request_start, [9] request_off, [15:10] zero
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata
);

    logic             r_out_valid;
    t_result          r_out;
    logic [CNT_W-1:0] r_hold_ticks;
    logic             adv;
    t_tick            tick;
    t_hold_info       info;
    t_result          result;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign adv           = s_axis_tvalid && s_axis_tready;

    always_comb begin
        tick.frame_valid        = s_axis_tuser;
        tick.ams_ok             = s_axis_tdata[0];
        tick.bspd_ok            = s_axis_tdata[1];
        tick.imd_ok             = s_axis_tdata[2];
        tick.shutdown_closed    = s_axis_tdata[3];
        tick.ready_to_drive     = s_axis_tdata[4];
        tick.inverter_temp_warn = s_axis_tdata[5];
        tick.accu_temp_warn     = s_axis_tdata[6];
        tick.inverter_fault     = s_axis_tdata[7];
        tick.button_pressed     = s_axis_tdata[8];
    end

    hsled_hold_cnt #(
        .STEP_TICKS(STEP_TICKS)
    ) u_hold_cnt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_button    (tick.button_pressed),
        .i_hold_ticks(r_hold_ticks),
        .o_info      (info)
    );

    hsled_lamp_ctl u_lamp_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_tick  (tick),
        .i_info  (info),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks <= HOLD_RESET;
        end else if (i_cfg_we) begin
            r_hold_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.req_off, r_out.req_start, r_out.pins};

`ifndef SYNTHESIS
    a_req_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.req_start && r_out.req_off))
        else $error("start and off requests issued in the same tick");

    a_req_clears_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.req_start || r_out.req_off)) |-> ((r_out.pins & SEQ_MASK) == '0))
        else $error("request issued with a sequence lamp still lit");

    a_out_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("output valid right after reset");

    a_release_no_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !tick.button_pressed) |=> !(r_out.req_start || r_out.req_off))
        else $error("request issued on a released tick");
`endif

endmodule

@@ tb/hold_to_start_button_led_sequencer_unit_test.sv @@
module hold_to_start_button_led_sequencer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hsled_pkg::*;

    localparam int STEP_TICKS = 60;
    localparam int QUIET_LIMIT = 2000;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [0] ams_ok, [1] bspd_ok, [2] imd_ok, [3] shutdown_closed, [4] ready_to_drive,
    // [5] inverter_temp_warn, [6] accu_temp_warn, [7] inverter_fault,
    // [8] button_pressed, [15:9] zero
    logic [15:0] s_axis_tdata = '0;
    // [0] frame_valid
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] lamp_temp_inv, [1] lamp_temp_accu, [2] lamp_ready, [3] lamp_shutdown,
    // [4] lamp_fault, [5] lamp_brake, [6] lamp_insulation, [7] lamp_accu_monitor,
    // [8] request_start, [9] request_off, [15:10] zero
    logic [15:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [11:0] i_cfg_wdata = '0;

    hold_to_start_button_led_sequencer_unit #(
        .STEP_TICKS(STEP_TICKS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    t_tick   pending_ticks[$];
    t_result expected_panels[$];
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      mismatch_count = 0;
    int      quiet_cycles = 0;

    // Panel state as the block should hold it.
    logic [CNT_W-1:0] panel_limit = HOLD_RESET;
    logic [CNT_W-1:0] panel_count = '0;
    logic             panel_mode = 1'b0;
    logic [7:0]       panel_status = '0;
    logic [7:0]       panel_pins = '0;

    function automatic t_result advance_panel(t_tick t);
        t_result r;
        int k;
        if (t.frame_valid) begin
            panel_status = '0;
            panel_status[B_TEMP_INV] = t.inverter_temp_warn;
            panel_status[B_TEMP_ACCU] = t.accu_temp_warn;
            panel_status[B_READY] = t.ready_to_drive;
            panel_status[B_SHUTDOWN] = t.shutdown_closed;
            panel_status[B_FAULT] = t.inverter_fault;
            panel_status[B_BRAKE] = ~t.bspd_ok;
            panel_status[B_INSUL] = ~t.imd_ok;
            panel_status[B_ACCU_MON] = ~t.ams_ok;
            panel_mode = t.ready_to_drive;
        end
        r = '0;
        if (t.button_pressed) begin
            if (panel_count != CNT_MAX)
                panel_count = panel_count + 1'b1;
            // In drive mode the sequence lamps come up in reverse order.
            for (k = 0; k < NUM_STEPS; k++)
                if (panel_count % (STEP_TICKS * (k + 1)) == 0)
                    panel_pins[panel_mode ? B_SHUTDOWN - k : B_TEMP_INV + k] = 1'b1;
            if (panel_count > panel_limit) begin
                r.req_off = panel_mode;
                r.req_start = ~panel_mode;
                panel_count = '0;
                panel_pins = panel_pins & ~SEQ_MASK;
            end
        end else begin
            panel_count = '0;
            panel_pins = panel_status;
        end
        r.pins = panel_pins;
        return r;
    endfunction

    function automatic string lamp_label(int b);
        case (b)
            B_TEMP_INV:  return "lamp_temp_inv";
            B_TEMP_ACCU: return "lamp_temp_accu";
            B_READY:     return "lamp_ready";
            B_SHUTDOWN:  return "lamp_shutdown";
            B_FAULT:     return "lamp_fault";
            B_BRAKE:     return "lamp_brake";
            B_INSUL:     return "lamp_insulation";
            default:     return "lamp_accu_monitor";
        endcase
    endfunction

    function automatic void check_field(string name, logic [5:0] want, logic [5:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic t_tick random_tick();
        logic [9:0] raw;
        raw = 10'($urandom);
        return raw;
    endfunction

    // One press of the button: a frame up front, on its own tick or on the first held tick,
    // a hold of the given length with the odd frame arriving mid-hold, then a short release.
    task automatic add_hold_run(int held);
        t_tick t;
        int i;
        t = random_tick();
        t.frame_valid = 1'b1;
        t.button_pressed = 1'($urandom_range(1));
        if (!t.button_pressed)
            pending_ticks.push_back(t);
        for (i = 0; i < held; i++) begin
            if (i > 0 || !t.button_pressed) begin
                t = random_tick();
                t.frame_valid = ($urandom_range(39) == 0);
                t.button_pressed = 1'b1;
            end
            pending_ticks.push_back(t);
        end
        repeat ($urandom_range(3, 1)) begin
            t = random_tick();
            t.button_pressed = 1'b0;
            t.frame_valid = ($urandom_range(3) == 0);
            pending_ticks.push_back(t);
        end
    endtask

    task automatic add_random_ticks(int n_items, int limit);
        int first;
        int len;
        int sel;
        first = pending_ticks.size();
        while (pending_ticks.size() - first < n_items) begin
            sel = $urandom_range(9);
            if (sel == 0) begin
                pending_ticks.push_back(random_tick());
            end else begin
                if (sel <= 3)
                    len = limit + 1 + $urandom_range(3);
                else if (sel == 4)
                    len = 2 * (limit + 1) + $urandom_range(2);
                else
                    len = $urandom_range((limit < 390) ? limit + 10 : 400, 1);
                add_hold_run(len);
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_ticks.size() != 0 || s_axis_tvalid || expected_panels.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_hold_limit(logic [11:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        panel_limit = value;
        @(negedge i_clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender side: present the next pending tick once the previous transaction is done.
    always @(posedge i_clk) begin : tick_driver
        t_tick t;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                t = pending_ticks.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= t.frame_valid;
                s_axis_tdata <= {7'b0, t.button_pressed, t.inverter_fault, t.accu_temp_warn,
                                 t.inverter_temp_warn, t.ready_to_drive, t.shutdown_closed,
                                 t.imd_ok, t.bspd_ok, t.ams_ok};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : panel_monitor
        t_result want;
        t_tick t;
        int b;
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_panels.size() == 0) begin
                    $error("m_axis transaction with nothing expected: %h", m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_panels.pop_front();
                    for (b = 0; b < 8; b++)
                        check_field(lamp_label(b), 6'(want.pins[b]), 6'(m_axis_tdata[b]));
                    check_field("request_start", 6'(want.req_start), 6'(m_axis_tdata[8]));
                    check_field("request_off", 6'(want.req_off), 6'(m_axis_tdata[9]));
                    check_field("unused bits", 6'd0, m_axis_tdata[15:10]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                t.frame_valid = s_axis_tuser;
                t.ams_ok = s_axis_tdata[0];
                t.bspd_ok = s_axis_tdata[1];
                t.imd_ok = s_axis_tdata[2];
                t.shutdown_closed = s_axis_tdata[3];
                t.ready_to_drive = s_axis_tdata[4];
                t.inverter_temp_warn = s_axis_tdata[5];
                t.accu_temp_warn = s_axis_tdata[6];
                t.inverter_fault = s_axis_tdata[7];
                t.button_pressed = s_axis_tdata[8];
                expected_panels.push_back(advance_panel(t));
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [9:0] raw;
        int b;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default hold limit, directed ticks first.
        set_idling(24, 67);
        // Bit order of raw: frame_valid, ams_ok, bspd_ok, imd_ok, shutdown_closed,
        // ready_to_drive, inverter_temp_warn, accu_temp_warn, inverter_fault, button.
        pending_ticks.push_back(10'h000);
        pending_ticks.push_back(10'h3C0);   // frame with every lamp dark
        pending_ticks.push_back(10'h23E);   // frame with every lamp lit, drive mode
        pending_ticks.push_back(10'h1FE);   // data without a frame is ignored
        for (b = 1; b <= 8; b++) begin
            raw = 10'h200 | (10'h1 << b);
            pending_ticks.push_back(raw);
        end
        pending_ticks.push_back(10'h211);   // frame and press in the same tick
        repeat (3) pending_ticks.push_back(10'h001);
        pending_ticks.push_back(10'h201);   // mode drops back mid-hold
        pending_ticks.push_back(10'h000);
        add_random_ticks(350, HOLD_RESET);

        wait_idle();
        write_hold_limit(12'd1);
        add_random_ticks(250, 1);

        // At the largest limit the count never exceeds it, so no request is issued.
        wait_idle();
        write_hold_limit(12'd4095);
        set_idling(67, 24);
        add_random_ticks(100, 300);

        wait_idle();
        write_hold_limit(12'd0);
        add_random_ticks(80, 0);

        wait_idle();
        write_hold_limit(12'($urandom_range(240, 61)));
        set_idling(0, 0);
        add_random_ticks(300, int'(panel_limit));

        wait_idle();
        write_hold_limit(12'($urandom_range(40, 2)));
        add_random_ticks(300, int'(panel_limit));

        wait_idle();
        repeat (4) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hdl/hsled_pkg.sv
hdl/hsled_hold_cnt.sv
hdl/hsled_lamp_ctl.sv
hdl/hold_to_start_button_led_sequencer_unit.sv
tb/hold_to_start_button_led_sequencer_unit_test.sv
